>>> hw/rtl/wdft5_pkg.sv
// Shared constants and coefficient helper for the five-point Winograd DFT core.
// No dependencies; imported by winograd_dft5_core.
package wdft5_pkg;

   localparam int unsigned SAMPLE_BITS_DEF    = 16;
   localparam int unsigned COEF_FRAC_BITS_DEF = 14;

   localparam int unsigned NUM_PTS     = 5;
   localparam int unsigned OUT_W       = 19;
   localparam int unsigned OUT_FIELDS  = 2 * NUM_PTS;
   localparam int unsigned OUT_TDATA_W = ((OUT_FIELDS * OUT_W + 7) / 8) * 8;

   // coefficients scaled by 2^30, rounded to nearest
   localparam longint K1_Q30 = -64'sd1342177280;
   localparam longint K2_Q30 = 64'sd600239927;
   localparam longint K3_Q30 = 64'sd1652318767;
   localparam longint K4_Q30 = 64'sd631129609;
   localparam longint K5_Q30 = 64'sd390059550;

   // requantise a Q30 constant to frac bits, nearest, ties away from zero
   function automatic longint coef_at(input longint q30, input int frac);
      longint mag;
      int     sh;
      logic   neg;
      sh  = 30 - frac;
      neg = (q30 < 0);
      mag = neg ? -q30 : q30;
      if (sh > 0) begin
         mag = (mag + (longint'(1) <<< (sh - 1))) >>> sh;
      end
      return neg ? -mag : mag;
   endfunction

endpackage

>>> hw/rtl/winograd_dft5_core.sv
// Five-point forward DFT, Winograd form, as a five-stage streaming pipeline.
// Depends on wdft5_pkg (coefficients, output widths).
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req     | in  | req_tvalid/req_tready | req_tdata: x0_re..x4_im, SAMPLE_BITS each
//  rsp     | out | rsp_tvalid/rsp_tready | rsp_tdata: y0_re..y4_im, 19 bits each
//
// One item per cycle while rsp_tready is high; rsp_tvalid is the stage 5 valid bit.
// Stages: pre-additions, constant products, rounding, post-additions, final sums
// with saturation into the output register.
// A stalled output holds; empty stages upstream keep filling, so ready only drops
// once every stage holds an item. Reset clears the stage valid bits only.
module winograd_dft5_core #(
   parameter int unsigned SAMPLE_BITS    = wdft5_pkg::SAMPLE_BITS_DEF,
   parameter int unsigned COEF_FRAC_BITS = wdft5_pkg::COEF_FRAC_BITS_DEF,
   parameter int unsigned IN_TDATA_W     = ((10 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // x0_re, x0_im, x1_re, x1_im, x2_re, x2_im, x3_re, x3_im, x4_re, x4_im
   input  logic [IN_TDATA_W-1:0]              req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // y0_re, y0_im, y1_re, y1_im, y2_re, y2_im, y3_re, y3_im, y4_re, y4_im
   output logic [wdft5_pkg::OUT_TDATA_W-1:0]  rsp_tdata
);
   import wdft5_pkg::*;

   localparam int unsigned S    = SAMPLE_BITS;
   localparam int unsigned F    = COEF_FRAC_BITS;
   localparam int unsigned C_W  = F + 2;
   localparam int unsigned V_W  = S + 2;
   localparam int unsigned P_W  = V_W + C_W;
   localparam int unsigned M_W  = S + 3;
   localparam int unsigned Q_W  = S + 5;
   localparam int unsigned T_W  = S + 4;
   localparam int unsigned Y_W  = (S + 6 > OUT_W + 1) ? S + 6 : OUT_W + 1;
   localparam int unsigned NST  = 5;

   localparam logic signed [C_W-1:0] C1 = C_W'(coef_at(K1_Q30, F));
   localparam logic signed [C_W-1:0] C2 = C_W'(coef_at(K2_Q30, F));
   localparam logic signed [C_W-1:0] C3 = C_W'(coef_at(K3_Q30, F));
   localparam logic signed [C_W-1:0] C4 = C_W'(coef_at(K4_Q30, F));
   localparam logic signed [C_W-1:0] C5 = C_W'(coef_at(K5_Q30, F));
   localparam logic [P_W:0]          HALF = (P_W + 1)'(longint'(1) <<< (F - 1));

   // symmetric round of a product: (p + half - [p<0]) >>> F
   function automatic logic signed [M_W-1:0] rnd(input logic signed [P_W-1:0] p);
      logic signed [P_W:0] t;
      t = {p[P_W-1], p} + HALF - (P_W + 1)'(p[P_W-1]);
      return M_W'(t >>> F);
   endfunction

   function automatic logic [OUT_W-1:0] sat(input logic signed [Y_W-1:0] y);
      logic [Y_W-OUT_W:0] hi;
      hi = y[Y_W-1:OUT_W-1];
      if ((&hi) || !(|hi)) begin
         return y[OUT_W-1:0];
      end else begin
         return y[Y_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
      end
   endfunction

   // ---------------- flow control ----------------
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] rdy;

   always_comb begin
      rdy[NST-1] = !vld_ff[NST-1] || rsp_tready;
      for (int i = NST - 2; i >= 0; i--) begin
         rdy[i] = !vld_ff[i] || rdy[i+1];
      end
   end

   assign req_tready = rdy[0];
   assign rsp_tvalid = vld_ff[NST-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (rdy[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NST; i++) begin
            if (rdy[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // ---------------- stage 1: pre-additions ----------------
   logic signed [S-1:0]   x [NUM_PTS][2];
   logic signed [S:0]     a [2];
   logic signed [S:0]     c [2];
   logic signed [M_W-1:0] s1_m0_in [2];
   logic signed [V_W-1:0] s1_s_in  [2];
   logic signed [V_W-1:0] s1_ac_in [2];
   logic signed [S:0]     s1_b_in  [2];
   logic signed [S:0]     s1_d_in  [2];
   logic signed [V_W-1:0] s1_g_in  [2];
   logic signed [M_W-1:0] s1_m0_ff [2];
   logic signed [V_W-1:0] s1_s_ff  [2];
   logic signed [V_W-1:0] s1_ac_ff [2];
   logic signed [S:0]     s1_b_ff  [2];
   logic signed [S:0]     s1_d_ff  [2];
   logic signed [V_W-1:0] s1_g_ff  [2];

   always_comb begin
      for (int n = 0; n < NUM_PTS; n++) begin
         for (int k = 0; k < 2; k++) begin
            x[n][k] = req_tdata[(2*n+k)*S +: S];
         end
      end
      for (int k = 0; k < 2; k++) begin
         a[k]        = (S+1)'(x[1][k]) + (S+1)'(x[4][k]);
         c[k]        = (S+1)'(x[3][k]) + (S+1)'(x[2][k]);
         s1_b_in[k]  = (S+1)'(x[1][k]) - (S+1)'(x[4][k]);
         s1_d_in[k]  = (S+1)'(x[3][k]) - (S+1)'(x[2][k]);
         s1_s_in[k]  = V_W'(a[k]) + V_W'(c[k]);
         s1_ac_in[k] = V_W'(a[k]) - V_W'(c[k]);
         s1_g_in[k]  = V_W'(s1_b_in[k]) + V_W'(s1_d_in[k]);
         s1_m0_in[k] = M_W'(x[0][k]) + M_W'(s1_s_in[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         s1_m0_ff <= s1_m0_in;
         s1_s_ff  <= s1_s_in;
         s1_ac_ff <= s1_ac_in;
         s1_b_ff  <= s1_b_in;
         s1_d_ff  <= s1_d_in;
         s1_g_ff  <= s1_g_in;
      end
   end

   // ---------------- stage 2: constant products ----------------
   logic signed [M_W-1:0] s2_m0_ff [2];
   logic signed [P_W-1:0] s2_p1_ff [2];
   logic signed [P_W-1:0] s2_p2_ff [2];
   logic signed [P_W-1:0] s2_p3_ff [2];
   logic signed [P_W-1:0] s2_p4_ff [2];
   logic signed [P_W-1:0] s2_p5_ff [2];

   always_ff @(posedge clock) begin
      if (rdy[1]) begin
         for (int k = 0; k < 2; k++) begin
            s2_m0_ff[k] <= s1_m0_ff[k];
            s2_p1_ff[k] <= P_W'(s1_s_ff[k])  * P_W'(C1);
            s2_p2_ff[k] <= P_W'(s1_ac_ff[k]) * P_W'(C2);
            s2_p3_ff[k] <= P_W'(s1_b_ff[k])  * P_W'(C3);
            s2_p4_ff[k] <= P_W'(s1_g_ff[k])  * P_W'(C4);
            s2_p5_ff[k] <= P_W'(s1_d_ff[k])  * P_W'(C5);
         end
      end
   end

   // ---------------- stage 3: rounding, j rotation ----------------
   logic signed [M_W-1:0] s3_m0_ff [2];
   logic signed [M_W-1:0] s3_m1_ff [2];
   logic signed [M_W-1:0] s3_m2_ff [2];
   logic signed [M_W-1:0] s3_m3_ff [2];
   logic signed [M_W-1:0] s3_m4_ff [2];
   logic signed [M_W-1:0] s3_m5_ff [2];

   always_ff @(posedge clock) begin
      if (rdy[2]) begin
         for (int k = 0; k < 2; k++) begin
            s3_m0_ff[k] <= s2_m0_ff[k];
            s3_m1_ff[k] <= rnd(s2_p1_ff[k]);
            s3_m2_ff[k] <= rnd(s2_p2_ff[k]);
         end
         // j*z: (re, im) -> (-im, re); rounding is symmetric so negating after is exact
         s3_m3_ff[0] <= -rnd(s2_p3_ff[1]);
         s3_m3_ff[1] <=  rnd(s2_p3_ff[0]);
         s3_m4_ff[0] <= -rnd(s2_p4_ff[1]);
         s3_m4_ff[1] <=  rnd(s2_p4_ff[0]);
         s3_m5_ff[0] <= -rnd(s2_p5_ff[1]);
         s3_m5_ff[1] <=  rnd(s2_p5_ff[0]);
      end
   end

   // ---------------- stage 4: post-additions ----------------
   logic signed [M_W-1:0] s4_y0_ff [2];
   logic signed [Q_W-1:0] s4_q_ff  [2];
   logic signed [Q_W-1:0] s4_r_ff  [2];
   logic signed [T_W-1:0] s4_t_ff  [2];
   logic signed [T_W-1:0] s4_v_ff  [2];

   always_ff @(posedge clock) begin
      if (rdy[3]) begin
         for (int k = 0; k < 2; k++) begin
            s4_y0_ff[k] <= s3_m0_ff[k];
            s4_q_ff[k]  <= Q_W'(s3_m0_ff[k]) + Q_W'(s3_m1_ff[k]) + Q_W'(s3_m2_ff[k]);
            s4_r_ff[k]  <= Q_W'(s3_m0_ff[k]) + Q_W'(s3_m1_ff[k]) - Q_W'(s3_m2_ff[k]);
            s4_t_ff[k]  <= T_W'(s3_m3_ff[k]) - T_W'(s3_m4_ff[k]);
            s4_v_ff[k]  <= T_W'(s3_m4_ff[k]) + T_W'(s3_m5_ff[k]);
         end
      end
   end

   // ---------------- stage 5: outputs, saturation ----------------
   logic [OUT_W-1:0] y_ff [OUT_FIELDS];

   always_ff @(posedge clock) begin
      if (rdy[4]) begin
         for (int k = 0; k < 2; k++) begin
            y_ff[k]     <= sat(Y_W'(s4_y0_ff[k]));
            y_ff[2 + k] <= sat(Y_W'(s4_q_ff[k]) - Y_W'(s4_t_ff[k]));
            y_ff[4 + k] <= sat(Y_W'(s4_r_ff[k]) - Y_W'(s4_v_ff[k]));
            y_ff[6 + k] <= sat(Y_W'(s4_r_ff[k]) + Y_W'(s4_v_ff[k]));
            y_ff[8 + k] <= sat(Y_W'(s4_q_ff[k]) + Y_W'(s4_t_ff[k]));
         end
      end
   end

   always_comb begin
      rsp_tdata = '0;
      for (int i = 0; i < OUT_FIELDS; i++) begin
         rsp_tdata[i*OUT_W +: OUT_W] = y_ff[i];
      end
   end

endmodule
